FILE: rtl/h2r_pkg.sv
// Package: fixed-point constants, codes and helpers for the HSL to RGB converter.
package h2r_pkg;

  // Field widths of the stream payload.
  localparam int HUE_W = 9;
  localparam int PCT_W = 7;
  localparam int CH_W = 8;
  localparam int S_TDATA_W = 24;  // hue, saturation, lightness (23 bits) padded to bytes
  localparam int M_TDATA_W = 24;  // red, green, blue

  // Fraction bits of the unsigned fixed-point arithmetic.
  localparam int FRAC_BITS = 16;
  localparam int FX_W = FRAC_BITS + 1;  // holds 0..ONE inclusive

  localparam longint OneL = longint'(1) << FRAC_BITS;
  localparam logic [FX_W-1:0] ONE_FX = FX_W'(OneL);
  localparam logic [FX_W-1:0] HALF_FX = FX_W'(OneL / 2);
  localparam logic [FX_W-1:0] SIXTH_FX = FX_W'(OneL / 6);
  localparam logic [FX_W-1:0] THIRD_FX = FX_W'(OneL / 3);
  localparam logic [FX_W-1:0] TWO_THIRDS_FX = FX_W'((2 * OneL) / 3);

  // Input ranges.
  localparam logic [HUE_W-1:0] HUE_SPAN = HUE_W'(360);
  localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(100);

  // Reciprocal multipliers: floor(x * ONE / D) == (x * ceil(2^(F+K) / D)) >> K
  // holds exactly for x * (rounding error) < 2^K, true for both divisors here.
  localparam int RCP_K = 18;
  localparam int RCP360_W = FRAC_BITS + 10;
  localparam int RCP100_W = FRAC_BITS + 12;
  localparam longint RcpBase = longint'(1) << (FRAC_BITS + RCP_K);
  localparam logic [RCP360_W-1:0] RCP360 = RCP360_W'((RcpBase + 359) / 360);
  localparam logic [RCP100_W-1:0] RCP100 = RCP100_W'((RcpBase + 99) / 100);

  // Ramp offset and scaled span widths.
  localparam int U_W = FRAC_BITS - 2;   // distance into a ramp edge, below ONE/4
  localparam int D6_W = FRAC_BITS + 3;  // 6 * (q - p), at most 6 * ONE

  // Segment of the hue ramp that a channel falls in.
  typedef enum logic [1:0] {
    RG_RISE = 2'd0,
    RG_HIGH = 2'd1,
    RG_FALL = 2'd2,
    RG_LOW  = 2'd3
  } region_e;

  // Scale a fixed-point channel to a byte: floor(v * 255 / ONE), clamped to 255.
  function automatic logic [CH_W-1:0] to_byte(input logic [FX_W:0] v);
    logic [FX_W+CH_W:0] scaled;
    logic [FX_W+CH_W-FRAC_BITS:0] whole;
    scaled = {v, {CH_W{1'b0}}} - (FX_W + CH_W + 1)'(v);
    whole = scaled[FX_W+CH_W:FRAC_BITS];
    if (whole > (FX_W + CH_W - FRAC_BITS + 1)'(255)) begin
      return {CH_W{1'b1}};
    end
    return whole[CH_W-1:0];
  endfunction

endpackage

FILE: rtl/hsl_to_rgb_converter.sv
// Top level: pipelined HSL to RGB pixel converter with stream handshakes.
//
//  Channel  | Direction | Transaction content
//  ---------+-----------+--------------------------------------------------
//  s_axis   | in        | hue [8:0], saturation % [15:9], lightness % [22:16]
//  m_axis   | out       | red [7:0], green [15:8], blue [23:16]
//
// One pixel enters per clock when nothing stalls. The five register stages
// are: input scaling, l*s product, q/p and hue segment selection, ramp
// products, and byte scaling into the output register. Every stage holds
// its own valid bit and loads whenever it is empty or the stage after it
// moves, so bubbles close up under back-pressure and s_axis stays ready
// while any stage is free. Reset clears the valid bits only.
module hsl_to_rgb_converter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [h2r_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,  // hue_degrees, saturation_pct, lightness_pct
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [h2r_pkg::M_TDATA_W-1:0]  m_axis_tdata_o   // red, green, blue
);
  import h2r_pkg::*;

  localparam int NSTG = 4;  // internal stages ahead of the output register
  localparam int HP_W = HUE_W + RCP360_W;
  localparam int SP_W = PCT_W + RCP100_W;

  // Stage valid bits and load enables.
  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] en;
  logic            out_vld_q;
  logic            out_en;

  assign out_en = !out_vld_q || m_axis_tready_i;
  assign en[NSTG-1] = !vld_q[NSTG-1] || out_en;
  for (genvar k = 0; k < NSTG - 1; k++) begin : g_en
    assign en[k] = !vld_q[k] || en[k+1];
  end
  assign s_axis_tready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= s_axis_tvalid_i;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
      if (out_en) begin
        out_vld_q <= vld_q[NSTG-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage A: wrap hue, saturate percentages, scale to fixed point.
  // ---------------------------------------------------------------------
  logic [HUE_W-1:0]    hue_in, hue_w;
  logic [PCT_W-1:0]    sat_in, lit_in, sat_c, lit_c;
  logic [HP_W-1:0]     h_prod;
  logic [SP_W-1:0]     s_prod, l_prod;
  logic [FRAC_BITS-1:0] h_a_d, h_a_q;
  logic [FX_W-1:0]     s_a_d, s_a_q, l_a_d, l_a_q;
  logic                zero_a_d, zero_a_q;

  always_comb begin
    hue_in = s_axis_tdata_i[HUE_W-1:0];
    sat_in = s_axis_tdata_i[HUE_W +: PCT_W];
    lit_in = s_axis_tdata_i[HUE_W+PCT_W +: PCT_W];
    hue_w = (hue_in >= HUE_SPAN) ? hue_in - HUE_SPAN : hue_in;
    sat_c = (sat_in > PCT_MAX) ? PCT_MAX : sat_in;
    lit_c = (lit_in > PCT_MAX) ? PCT_MAX : lit_in;
    h_prod = HP_W'(hue_w) * HP_W'(RCP360);
    s_prod = SP_W'(sat_c) * SP_W'(RCP100);
    l_prod = SP_W'(lit_c) * SP_W'(RCP100);
    h_a_d = h_prod[RCP_K +: FRAC_BITS];
    s_a_d = s_prod[RCP_K +: FX_W];
    l_a_d = l_prod[RCP_K +: FX_W];
    zero_a_d = (sat_c == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      h_a_q <= h_a_d;
      s_a_q <= s_a_d;
      l_a_q <= l_a_d;
      zero_a_q <= zero_a_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage B: truncated product l*s.
  // ---------------------------------------------------------------------
  logic [2*FX_W-1:0]    ls_prod;
  logic [FX_W-1:0]      ls_b_q, s_b_q, l_b_q;
  logic [FRAC_BITS-1:0] h_b_q;
  logic                 zero_b_q;

  assign ls_prod = (2 * FX_W)'(l_a_q) * (2 * FX_W)'(s_a_q);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      ls_b_q <= ls_prod[FRAC_BITS +: FX_W];
      s_b_q <= s_a_q;
      l_b_q <= l_a_q;
      h_b_q <= h_a_q;
      zero_b_q <= zero_a_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage C: form q, p and 6*(q-p); place each channel's hue on the ramp.
  // ---------------------------------------------------------------------
  logic [FX_W:0]    lq, lsum;
  logic [FX_W-1:0]  q_c_d, p_c_d, dd;
  logic [FX_W-1:0]  tsum, tdiff;
  logic [FX_W-1:0]  t [3];
  region_e          rg_c_d [3];
  logic [U_W-1:0]   u_c_d [3];
  logic [FX_W-1:0]  q_c_q, p_c_q, l_c_q;
  logic [D6_W-1:0]  d6_c_q;
  region_e          rg_c_q [3];
  logic [U_W-1:0]   u_c_q [3];
  logic             zero_c_q;

  always_comb begin
    lq = (FX_W + 1)'(l_b_q) + (FX_W + 1)'(ls_b_q);
    lsum = (FX_W + 1)'(l_b_q) + (FX_W + 1)'(s_b_q);
    if (l_b_q < HALF_FX) begin
      q_c_d = lq[FX_W-1:0];
      p_c_d = l_b_q - ls_b_q;
    end else begin
      q_c_d = FX_W'(lsum - (FX_W + 1)'(ls_b_q));
      // Drop negative p to zero.
      p_c_d = (lq >= (FX_W + 1)'(s_b_q)) ? FX_W'(lq - (FX_W + 1)'(s_b_q)) : '0;
    end
    dd = q_c_d - p_c_d;

    // Red at h+1/3, green at h, blue at h-1/3, each wrapped once.
    tsum = FX_W'(h_b_q) + THIRD_FX;
    t[0] = (tsum > ONE_FX) ? tsum - ONE_FX : tsum;
    t[1] = FX_W'(h_b_q);
    t[2] = (FX_W'(h_b_q) < THIRD_FX) ? FX_W'(h_b_q) + (ONE_FX - THIRD_FX)
                                      : FX_W'(h_b_q) - THIRD_FX;

    for (int c = 0; c < 3; c++) begin
      tdiff = TWO_THIRDS_FX - t[c];
      if (t[c] < SIXTH_FX) begin
        rg_c_d[c] = RG_RISE;
        u_c_d[c] = t[c][U_W-1:0];
      end else if (t[c] < HALF_FX) begin
        rg_c_d[c] = RG_HIGH;
        u_c_d[c] = '0;
      end else if (t[c] < TWO_THIRDS_FX) begin
        rg_c_d[c] = RG_FALL;
        u_c_d[c] = tdiff[U_W-1:0];
      end else begin
        rg_c_d[c] = RG_LOW;
        u_c_d[c] = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      q_c_q <= q_c_d;
      p_c_q <= p_c_d;
      d6_c_q <= {dd, 2'b00} + D6_W'({dd, 1'b0});
      l_c_q <= l_b_q;
      zero_c_q <= zero_b_q;
      for (int c = 0; c < 3; c++) begin
        rg_c_q[c] <= rg_c_d[c];
        u_c_q[c] <= u_c_d[c];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage D: ramp products 6*d*u, truncated once.
  // ---------------------------------------------------------------------
  localparam int RP_W = D6_W + U_W;
  logic [RP_W-1:0]  rprod [3];
  logic [FX_W-1:0]  ramp_d_q [3];
  region_e          rg_d_q [3];
  logic [FX_W-1:0]  q_d_q, p_d_q, l_d_q;
  logic             zero_d_q;

  for (genvar c = 0; c < 3; c++) begin : g_ramp
    assign rprod[c] = RP_W'(d6_c_q) * RP_W'(u_c_q[c]);
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int c = 0; c < 3; c++) begin
        ramp_d_q[c] <= rprod[c][FRAC_BITS +: FX_W];
        rg_d_q[c] <= rg_c_q[c];
      end
      q_d_q <= q_c_q;
      p_d_q <= p_c_q;
      l_d_q <= l_c_q;
      zero_d_q <= zero_c_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage E: pick the segment value, scale to bytes, hold in output register.
  // ---------------------------------------------------------------------
  logic [FX_W:0]   chv [3];
  logic [CH_W-1:0] byte_d [3];
  logic [CH_W-1:0] grey;
  logic [M_TDATA_W-1:0] out_data_q;

  always_comb begin
    grey = to_byte((FX_W + 1)'(l_d_q));
    for (int c = 0; c < 3; c++) begin
      case (rg_d_q[c])
        RG_RISE, RG_FALL: chv[c] = (FX_W + 1)'(p_d_q) + (FX_W + 1)'(ramp_d_q[c]);
        RG_HIGH:          chv[c] = (FX_W + 1)'(q_d_q);
        RG_LOW:           chv[c] = (FX_W + 1)'(p_d_q);
        default:          chv[c] = (FX_W + 1)'(p_d_q);
      endcase
      // Zero saturation: every channel takes the lightness.
      byte_d[c] = zero_d_q ? grey : to_byte(chv[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_data_q <= {byte_d[2], byte_d[1], byte_d[0]};
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o = out_data_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_scaled_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> (s_a_q <= ONE_FX) && (l_a_q <= ONE_FX))
    else $error("scaled saturation or lightness above one");

  a_p_below_q: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> (p_c_q <= q_c_q) && (q_c_q <= ONE_FX))
    else $error("p above q or q above one");

  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i && (&vld_q)))
    else $error("input stalled while the pipeline has room");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NSTG-1] && out_en) |=> m_axis_tvalid_o)
    else $error("result lost between last stage and output register");

endmodule
